// File: design/hzd_pkg.sv
package hzd_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_NOMAP  = 2'd2
  } hzd_kind_e;

  // Byte codes and ranges of the HZ stream
  localparam logic [7:0]  ChTilde    = 8'h7E;
  localparam logic [7:0]  ChOpen     = 8'h7B;
  localparam logic [7:0]  ChClose    = 8'h7D;
  localparam logic [7:0]  SevenLo    = 8'h21;
  localparam logic [7:0]  SevenHi    = 8'h7E;
  localparam logic [7:0]  EightLo    = 8'h81;
  localparam logic [7:0]  EightHi    = 8'hFE;
  localparam logic [7:0]  TrailLo    = 8'h40;
  localparam logic [7:0]  SpaceCh    = 8'h20;
  localparam logic [7:0]  HighBit    = 8'h80;
  localparam logic [15:0] NomapCode  = 16'hFFFD;

  // Default depth of the result queue (at least 2)
  localparam int unsigned OutDepthDef = 4;

  typedef struct packed {
    hzd_kind_e   kind;
    logic [15:0] code;
    logic        last;
  } hzd_result_t;

  typedef struct packed {
    logic       gb_mode;
    logic       lead_pending;
    logic [7:0] lead_byte;
    logic       char_seen;
  } hzd_state_t;

endpackage

// File: design/hzd_decode.sv
module hzd_decode
  import hzd_pkg::*;
(
  input  hzd_state_t  st_i,
  input  logic [7:0]  byte_i,
  output hzd_state_t  st_o,
  output hzd_result_t res0_o,
  output hzd_result_t res1_o,
  output logic [1:0]  res_cnt_o
);

  logic        e0_vld;
  hzd_kind_e   e0_kind;
  logic [15:0] e0_code;
  logic        e1_vld;
  hzd_kind_e   e1_kind;
  logic [15:0] e1_code;
  logic        fresh;
  logic        is_lead;
  logic [7:0]  lead;
  logic        printable;

  // Classify the byte as a fresh lead under the current mode
  assign is_lead = (byte_i == ChTilde) ||
                   (st_i.gb_mode && (((byte_i >= SevenLo) && (byte_i <= SevenHi)) ||
                                     ((byte_i >= EightLo) && (byte_i <= EightHi))));
  assign lead      = st_i.lead_byte;
  assign printable = !byte_i[7] && (byte_i > SpaceCh);

  // Resolve a pending lead, then handle the byte fresh where needed
  always_comb begin
    st_o    = st_i;
    e0_vld  = 1'b0;
    e0_kind = KIND_NOMAP;
    e0_code = NomapCode;
    e1_vld  = 1'b0;
    e1_kind = KIND_NOMAP;
    e1_code = NomapCode;
    fresh   = 1'b0;

    if (!st_i.lead_pending) begin
      fresh = 1'b1;
    end else begin
      st_o.lead_pending = 1'b0;
      st_o.lead_byte    = '0;
      if (lead[7]) begin
        e0_vld = 1'b1;
        if ((lead >= EightLo) && (lead <= EightHi) &&
            (byte_i >= TrailLo) && (byte_i <= EightHi)) begin
          e0_kind = KIND_PAIR;
          e0_code = {lead, byte_i};
        end
        st_o.char_seen = 1'b1;
      end else if (lead == ChTilde) begin
        if (byte_i == ChOpen) begin
          st_o.gb_mode   = 1'b1;
          st_o.char_seen = 1'b0;
        end else if (byte_i == ChClose) begin
          st_o.gb_mode   = 1'b0;
          e0_vld         = !st_i.char_seen;
          st_o.char_seen = 1'b0;
        end else if (byte_i == ChTilde) begin
          e0_vld         = 1'b1;
          e0_kind        = KIND_DIRECT;
          e0_code        = {8'h00, ChTilde};
          st_o.char_seen = 1'b1;
        end else begin
          // Undefined escape: flag it in ASCII mode or when the byte is printable, then reprocess the byte
          e0_vld = printable || !st_i.gb_mode;
          fresh  = 1'b1;
        end
      end else if (st_i.gb_mode) begin
        e0_vld = 1'b1;
        if ((lead >= SevenLo) && (lead <= SevenHi) &&
            (byte_i >= SevenLo) && (byte_i <= SevenHi)) begin
          e0_kind = KIND_PAIR;
          e0_code = {lead | HighBit, byte_i | HighBit};
        end
        st_o.char_seen = 1'b1;
      end else begin
        e0_vld = 1'b1;
      end
    end

    if (fresh) begin
      if (is_lead) begin
        st_o.lead_pending = 1'b1;
        st_o.lead_byte    = byte_i;
      end else begin
        e1_vld = 1'b1;
        if (!byte_i[7]) begin
          e1_kind = KIND_DIRECT;
          e1_code = {8'h00, byte_i};
        end
      end
    end
  end

  // Pack results in order and mark the final one
  always_comb begin
    res0_o    = '{kind: e0_kind, code: e0_code, last: 1'b1};
    res1_o    = '{kind: e1_kind, code: e1_code, last: 1'b1};
    res_cnt_o = 2'd0;
    if (e0_vld && e1_vld) begin
      res0_o.last = 1'b0;
      res_cnt_o   = 2'd2;
    end else if (e0_vld) begin
      res_cnt_o = 2'd1;
    end else if (e1_vld) begin
      res0_o    = res1_o;
      res_cnt_o = 2'd1;
    end
  end

endmodule

// File: design/hzd_out_fifo.sv
module hzd_out_fifo
  import hzd_pkg::*;
#(
  parameter int unsigned Depth = OutDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hzd_result_t res0_i,
  input  hzd_result_t res1_i,
  input  logic [1:0]  push_cnt_i,
  input  logic        pop_i,
  output hzd_result_t head_o,
  output logic        not_empty_o,
  output logic        almost_full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] StallAt = CntW'(Depth - 2);

  hzd_result_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_nxt, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nxt = ptr_inc(wr_ptr_q);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_cnt_i == 2'd1) begin
      wr_ptr_d = wr_nxt;
    end else if (push_cnt_i == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_nxt);
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_cnt_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign not_empty_o   = (cnt_q != '0);
  assign almost_full_o = (cnt_q > StallAt);

endmodule

// File: design/hz_gb2312_stream_decoder.sv
// HZ / GB2312 stream decoder.
// Input channel: one byte of an HZ encoded stream per request on
// in_byte_i, with in_valid_i / in_stall_o. Output channel: results on
// kind_o, code_o and last_o with out_valid_o / out_stall_i. A byte gives
// zero, one or two results; last_o marks the final result of a byte.
// Kind 0 is a direct character, kind 1 a GB code pair (lead in the upper
// byte) for an external table, kind 2 a no-mapping result (0xFFFD).
// Results are written into the result queue when their byte is
// accepted and shown from its head. Throughput: one byte per cycle
// while in_stall_o is low; decoding is a single combinational pass
// from the mode/lead state into a small result queue. The queue takes
// two results per cycle and drains one, so a stream of two-result
// bytes is bounded by the single output port.
// in_stall_o rises when the queue cannot take two more results; while the
// receiver stalls, the head result holds and bytes are accepted until the
// queue fills. Reset returns to ASCII mode with no pending lead byte and
// an empty queue.
module hz_gb2312_stream_decoder
  import hzd_pkg::*;
#(
  parameter int unsigned OutDepth = OutDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] code_o,
  output logic        last_o
);

  hzd_state_t  st_q, st_d, st_nxt;
  hzd_result_t res0, res1, head;
  logic [1:0]  res_cnt, push_cnt;
  logic        in_acc, pop, almost_full;

  assign in_acc = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  hzd_decode u_decode (
    .st_i      (st_q),
    .byte_i    (in_byte_i),
    .st_o      (st_nxt),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  // Hold decoder state unless a byte is accepted
  assign st_d     = in_acc ? st_nxt : st_q;
  assign push_cnt = in_acc ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  hzd_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res0_i        (res0),
    .res1_i        (res1),
    .push_cnt_i    (push_cnt),
    .pop_i         (pop),
    .head_o        (head),
    .not_empty_o   (out_valid_o),
    .almost_full_o (almost_full)
  );

  assign in_stall_o = almost_full;
  assign kind_o     = head.kind;
  assign code_o     = head.code;
  assign last_o     = head.last;

  // A non-tilde lead can only be pending in GB mode
  a_lead_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.lead_pending && !st_q.gb_mode) |-> (st_q.lead_byte == ChTilde))
    else $error("non-tilde lead pending in ASCII mode");

  // No-mapping results always carry the replacement code
  a_nomap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_NOMAP)) |-> (code_o == NomapCode))
    else $error("no-mapping result with wrong code");

  // A two-result byte never ends on its first result
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (res_cnt == 2'd2)) |-> (!res0.last && res1.last))
    else $error("result ordering broken for two-result byte");

  // Pair codes always have the lead high bit set (8-bit trails may be low)
  a_pair_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_PAIR)) |-> code_o[15])
    else $error("GB pair code without lead high bit");

endmodule

// File: tb/sv/hz_gb2312_stream_decoder_checker.sv
module hz_gb2312_stream_decoder_checker
  import hzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] code_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder state as seen by the predictor
  logic        gb_mode;
  logic        lead_pending;
  logic [7:0]  lead_byte;
  logic        char_seen;

  // Results predicted but not yet seen on the output
  hzd_result_t decoded_q[$];
  int unsigned byte_results;
  int unsigned fail_count;

  function automatic bit is_seven(logic [7:0] b);
    return b >= SevenLo && b <= SevenHi;
  endfunction

  function automatic bit is_eight(logic [7:0] b);
    return b >= EightLo && b <= EightHi;
  endfunction

  function automatic void add_result(hzd_kind_e k, logic [15:0] c);
    hzd_result_t r;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    decoded_q.push_back(r);
    byte_results++;
  endfunction

  // Handle a byte with no lead byte pending
  function automatic void take_fresh(logic [7:0] b);
    if (b == ChTilde || (gb_mode && (is_seven(b) || is_eight(b)))) begin
      lead_byte    = b;
      lead_pending = 1'b1;
    end else if (b[7]) begin
      add_result(KIND_NOMAP, NomapCode);
    end else begin
      add_result(KIND_DIRECT, {8'h00, b});
    end
  endfunction

  // Predict the results of one accepted request
  function automatic void decode_hz_byte(logic [7:0] b);
    logic [7:0]  lead;
    hzd_result_t tail;
    byte_results = 0;
    if (!lead_pending) begin
      take_fresh(b);
    end else begin
      lead         = lead_byte;
      lead_pending = 1'b0;
      lead_byte    = 8'h00;
      if (lead[7]) begin
        // 8-bit pair
        if (is_eight(lead) && b >= TrailLo && b <= EightHi) begin
          add_result(KIND_PAIR, {lead, b});
        end else begin
          add_result(KIND_NOMAP, NomapCode);
        end
        char_seen = 1'b1;
      end else if (lead == ChTilde) begin
        if (b == ChOpen) begin
          gb_mode   = 1'b1;
          char_seen = 1'b0;
        end else if (b == ChClose) begin
          gb_mode = 1'b0;
          if (!char_seen) add_result(KIND_NOMAP, NomapCode);
          char_seen = 1'b0;
        end else if (b == ChTilde) begin
          add_result(KIND_DIRECT, {8'h00, ChTilde});
          char_seen = 1'b1;
        end else begin
          // Undefined escape: bytes with bit 7 set count as negative
          if ((!b[7] && b > SpaceCh) || !gb_mode) add_result(KIND_NOMAP, NomapCode);
          take_fresh(b);
        end
      end else if (gb_mode) begin
        // 7-bit pair in GB mode
        if (is_seven(lead) && is_seven(b)) begin
          add_result(KIND_PAIR, {lead | HighBit, b | HighBit});
        end else begin
          add_result(KIND_NOMAP, NomapCode);
        end
        char_seen = 1'b1;
      end else begin
        add_result(KIND_NOMAP, NomapCode);
      end
    end
    // Mark the final result of this request
    if (byte_results != 0) begin
      tail = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endfunction

  // Compare outputs first, then predict from the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    hzd_result_t want;
    if (!rst_ni) begin
      gb_mode      = 1'b0;
      lead_pending = 1'b0;
      lead_byte    = 8'h00;
      char_seen    = 1'b0;
      decoded_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $error("result with none expected: kind %0d code %h last %b",
                 kind_i, code_i, last_i);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_i);
            fail_count++;
          end
          if (code_i !== want.code) begin
            $error("code: expected %h, actual %h", want.code, code_i);
            fail_count++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_hz_byte(in_byte_i);
    end
    fail_count_o <= fail_count;
    pending_o    <= decoded_q.size();
  end

endmodule

// File: tb/sv/hz_gb2312_stream_decoder_test.sv
module hz_gb2312_stream_decoder_test
  import hzd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteTarget = 1400;
  localparam int unsigned IdleLimit  = 500;
  localparam int unsigned TailCycles = 4;

  logic        clk_i = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall_o;
  logic [7:0]  in_byte;
  logic        out_valid_o;
  logic        out_stall;
  logic [1:0]  kind_o;
  logic [15:0] code_o;
  logic        last_o;
  int unsigned fail_count;
  int unsigned pending;

  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  always #6 clk_i = ~clk_i;

  hz_gb2312_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .kind_o      (kind_o),
    .code_o      (code_o),
    .last_o      (last_o)
  );

  hz_gb2312_stream_decoder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall),
    .kind_i       (kind_o),
    .code_i       (code_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Abort when no request moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one byte, after a random gap, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_escape(input logic [7:0] b);
    send_byte(ChTilde);
    send_byte(b);
  endtask

  // One pair inside a GB block: 7-bit, 8-bit or malformed
  task automatic send_gb_pair();
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        send_byte(8'($urandom_range(SevenLo, SevenHi - 1)));
        send_byte(8'($urandom_range(SevenLo, SevenHi)));
      end
      3, 4: begin
        send_byte(8'($urandom_range(EightLo, EightHi)));
        send_byte(8'($urandom_range(TrailLo, EightHi)));
      end
      default: begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Receiver: draw a stall for every result, then take it
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = recv_idle_on ? $urandom_range(0, 8) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    idle_cycles = 0;
    bytes_sent  = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: ASCII extremes, escapes, pairs and undefined escapes
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_escape(ChTilde);             // literal tilde, sets char_seen
    send_escape(ChClose);             // close after a character: no result
    send_escape(ChClose);             // empty close: no mapping
    send_escape(8'h41);               // undefined in ASCII: error then 'A'
    send_escape(8'h85);               // undefined in ASCII, high byte: two errors
    send_escape(ChOpen);
    send_escape(ChClose);             // empty GB block
    send_escape(ChOpen);
    send_byte(SevenLo);
    send_byte(SevenHi);               // 7-bit pair, top trail
    send_byte(SevenLo);
    send_byte(SpaceCh);               // bad 7-bit trail
    send_byte(EightLo);
    send_byte(TrailLo);               // lowest 8-bit pair
    send_byte(EightHi);
    send_byte(8'hFF);                 // bad 8-bit trail
    send_escape(8'h41);               // undefined, printable: 'A' becomes lead
    send_byte(8'h42);
    send_escape(8'h0A);               // undefined, control: passes through
    send_escape(8'h90);               // undefined, high byte: held as lead
    send_byte(8'h41);
    send_byte(8'h80);                 // lone high byte in GB mode
    send_byte(8'h0A);
    send_escape(ChClose);

    // Random: mostly well-formed segments with random content, some noise
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 15) == 0) send_idle_on = !send_idle_on;
      if ($urandom_range(0, 15) == 0) recv_idle_on = !recv_idle_on;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_byte(8'($urandom_range(0, 127)));
          end
        end
        3, 4, 5: begin
          send_escape(ChOpen);
          n = $urandom_range(1, 5);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_escape(ChTilde);
            else send_gb_pair();
          end
          // leave some blocks open
          if ($urandom_range(0, 7) != 0) send_escape(ChClose);
        end
        6: send_escape(ChTilde);
        7: send_escape(8'($urandom_range(0, 255)));
        8: send_byte(8'($urandom_range(0, 255)));
        default: begin
          if ($urandom_range(0, 1) == 0) send_escape(ChOpen);
          send_escape(ChClose);
        end
      endcase
    end
    in_valid <= 1'b0;

    // Drain the outstanding results, then allow for the output latency
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hzd_pkg.sv
design/hzd_decode.sv
design/hzd_out_fifo.sv
design/hz_gb2312_stream_decoder.sv
tb/sv/hz_gb2312_stream_decoder_checker.sv
tb/sv/hz_gb2312_stream_decoder_test.sv
